// ===== hdl/bgeh_pkg.sv =====
package bgeh_pkg;

  localparam int unsigned SMOOTH_FRAC_BITS = 16;

  localparam int unsigned MV_W    = 13;
  localparam int unsigned GAIN_W  = 17;
  localparam int unsigned HYST_W  = 7;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned CFG_W   = 17;
  localparam int unsigned IDX_W   = 2;

  // gain is a Q16 fraction regardless of the average's fraction bits
  localparam int unsigned GAIN_FRAC = 16;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_FRAC);

  localparam logic [MV_W-1:0] NO_BATTERY_RST = MV_W'(3000);
  localparam logic [GAIN_W-1:0] EMA_GAIN_RST = GAIN_W'(3277);
  localparam logic [HYST_W-1:0] HYST_RST = HYST_W'(3);

  // level curve breakpoints in mV, with the rounding bias folded in
  localparam logic [MV_W-1:0] MV_EMPTY   = MV_W'(3300);
  localparam logic [MV_W-1:0] MV_MID     = MV_W'(3700);
  localparam logic [MV_W-1:0] LOW_BIAS   = MV_W'(3300 - 4);
  localparam logic [MV_W-1:0] HIGH_BIAS  = MV_W'(3700 - 5);
  localparam int unsigned     LOW_SHIFT  = 3;

  // n / 10 as (n * 52429) >> 19, exact for any 13-bit n
  localparam int unsigned     DIV10_MUL_W = 16;
  localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = DIV10_MUL_W'(52429);
  localparam int unsigned     DIV10_SHIFT = 19;

  localparam logic [6:0] PCT_MID  = 7'd50;
  localparam logic [6:0] PCT_FULL = 7'd100;
  localparam logic [LEVEL_W-1:0] LEVEL_NONE = '1;

  typedef enum logic [IDX_W-1:0] {
    REG_NO_BATTERY = 2'd0,
    REG_EMA_GAIN   = 2'd1,
    REG_HYSTERESIS = 2'd2
  } reg_idx_e;

endpackage

// ===== hdl/battery_gauge_ema_hysteresis.sv =====
// Channel   Dir  Payload                          Request taken when
// s_axis    in   tdata[12:0] battery_mv           s_axis_tvalid && s_axis_tready
// m_axis    out  tdata[7:0]  level_pct (signed)   m_axis_tvalid && m_axis_tready
// cfg       in   cfg_idx_i, cfg_wdata_i           cfg_we_i
//
// One request per cycle unless the output stalls; stages one and two are each registered.
// Stage one: average update (one 13+F by 17 multiply); stage two: level map and hysteresis.
// Reset clears the average, shows no battery and loads register defaults.
// A stalled output holds both stages; input is still taken while the middle stage is empty.
module battery_gauge_ema_hysteresis
  import bgeh_pkg::*;
#(
  parameter int unsigned SmoothFracBits = SMOOTH_FRAC_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // [12:0] battery_mv
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // [7:0] level_pct
  input  logic                cfg_we_i,
  input  logic [IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i
);

  localparam int unsigned AvgW  = MV_W + SmoothFracBits;
  localparam int unsigned ProdW = AvgW + GAIN_W;

  logic [MV_W-1:0]   no_batt_q;
  logic [GAIN_W-1:0] gain_q;
  logic [HYST_W-1:0] hyst_q;

  logic [AvgW-1:0]   avg_q, avg_d;
  logic              s1_valid_q, s1_absent_q;
  logic              out_valid_q;
  logic [LEVEL_W-1:0] shown_q, shown_d;

  logic s_accept, advance, s1_en;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s1_en         = !s1_valid_q || advance;
  assign s_axis_tready = s1_en;
  assign s_accept      = s_axis_tvalid && s1_en;

  // ---- stage one: average update
  logic [MV_W-1:0]   mv;
  logic              absent;
  logic [AvgW-1:0]   target, mag, step;
  logic [GAIN_W-1:0] g_sat;
  logic              up;
  logic [ProdW-1:0]  prod;

  assign mv     = s_axis_tdata[MV_W-1:0];
  assign absent = mv < no_batt_q;
  assign target = {mv, {SmoothFracBits{1'b0}}};
  assign g_sat  = (gain_q > GAIN_ONE) ? GAIN_ONE : gain_q;
  assign up     = target >= avg_q;
  assign mag    = up ? (target - avg_q) : (avg_q - target);
  assign prod   = ProdW'(mag) * ProdW'(g_sat) + ProdW'(1 << (GAIN_FRAC - 1));
  assign step   = prod[GAIN_FRAC +: AvgW];

  always_comb begin
    if (absent) begin
      avg_d = '0;
    end else if (avg_q == '0) begin
      avg_d = target;
    end else if (up) begin
      avg_d = avg_q + step;
    end else begin
      avg_d = avg_q - step;
    end
  end

  // ---- stage two: level map and hysteresis (avg_q still belongs to the stage-one request)
  logic [MV_W-1:0]   ip, n_low, n_high;
  logic [MV_W+DIV10_MUL_W-1:0] q10;
  logic [6:0]        tens, pct;
  logic [LEVEL_W:0]  diff;
  logic [LEVEL_W-1:0] mag_diff;

  assign ip     = avg_q[AvgW-1 -: MV_W];
  assign n_low  = ip - LOW_BIAS;
  assign n_high = ip - HIGH_BIAS;
  assign q10    = (MV_W + DIV10_MUL_W)'(n_high) * (MV_W + DIV10_MUL_W)'(DIV10_MUL);
  assign tens   = (q10[MV_W+DIV10_MUL_W-1:DIV10_SHIFT] >= (MV_W+DIV10_MUL_W-DIV10_SHIFT)'(PCT_MID))
                  ? PCT_MID : q10[DIV10_SHIFT +: 7];

  always_comb begin
    if (ip < MV_EMPTY) begin
      pct = '0;
    end else if (ip < MV_MID) begin
      pct = 7'(n_low >> LOW_SHIFT);
    end else begin
      pct = PCT_MID + tens;
    end
  end

  assign diff     = {2'b00, pct} - {shown_q[LEVEL_W-1], shown_q};
  assign mag_diff = diff[LEVEL_W] ? LEVEL_W'(-diff) : diff[LEVEL_W-1:0];

  always_comb begin
    shown_d = shown_q;
    if (s1_absent_q) begin
      shown_d = LEVEL_NONE;
    end else if (shown_q[LEVEL_W-1] || mag_diff >= LEVEL_W'(hyst_q) ||
                 pct == PCT_FULL || pct == '0) begin
      shown_d = {1'b0, pct};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      no_batt_q   <= NO_BATTERY_RST;
      gain_q      <= EMA_GAIN_RST;
      hyst_q      <= HYST_RST;
      avg_q       <= '0;
      s1_valid_q  <= 1'b0;
      s1_absent_q <= 1'b0;
      out_valid_q <= 1'b0;
      shown_q     <= LEVEL_NONE;
      m_axis_tdata <= LEVEL_NONE;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_NO_BATTERY: no_batt_q <= cfg_wdata_i[MV_W-1:0];
          REG_EMA_GAIN:   gain_q    <= cfg_wdata_i[GAIN_W-1:0];
          REG_HYSTERESIS: hyst_q    <= cfg_wdata_i[HYST_W-1:0];
          default: ;
        endcase
      end
      if (s1_en) begin
        s1_valid_q <= s_accept;
        if (s_accept) begin
          s1_absent_q <= absent;
        end
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
        if (s1_valid_q) begin
          shown_q      <= shown_d;
          m_axis_tdata <= shown_d;
        end
      end
      if (s_accept) begin
        avg_q <= avg_d;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;

endmodule

// ===== hdl/bgeh_checker.sv =====
module bgeh_checker
  import bgeh_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  logic s_accept;
  assign s_accept = s_axis_tvalid && s_axis_tready;

  // a waiting consumer never blocks the input side
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is drained");

  // a taken request reaches the output when the output side is open as it leaves stage one
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept ##1 m_axis_tready) |=> m_axis_tvalid)
    else $error("result missing two cycles after request");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata == LEVEL_NONE || m_axis_tdata <= 8'd100))
    else $error("level out of range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind battery_gauge_ema_hysteresis bgeh_checker u_bgeh_checker (.*);
